>>> hw/rtl/resp_request_parser_top_defines.svh
// Assertion macros for the request parser RTL.
// Used by resp_request_parser_top; expects clk and rst_n in scope.
`ifndef RESP_REQUEST_PARSER_TOP_DEFINES_SVH
`define RESP_REQUEST_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define RRP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrp: assertion failed");
// Antecedent implies consequent in the next cycle.
`define RRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrp: assertion failed");
`else
`define RRP_ASSERT_NOW(lbl, ante, cons)
`define RRP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/rrp_pkg.sv
// Shared types and constants for the request parser.
// No dependencies.
`default_nettype none

package rrp_pkg;

  localparam int LEN_BITS_DEF = 16;
  localparam int ACC_W        = 17;
  localparam int CNT_W        = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [ACC_W-1:0] ACC_MAX = 17'h1FFFF;
  localparam logic [CFG_W-1:0] CFG_RESET_VAL = 16'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELEMENTS = 1'b1;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [2:0] EV_DATA  = 3'd0;
  localparam logic [2:0] EV_DONE  = 3'd1;
  localparam logic [2:0] EV_NULL  = 3'd2;
  localparam logic [2:0] EV_EMPTY = 3'd3;
  localparam logic [2:0] EV_ERROR = 3'd4;

  localparam logic [2:0] ERR_ARRAY_HDR = 3'd0;
  localparam logic [2:0] ERR_BULK_HDR  = 3'd1;
  localparam logic [2:0] ERR_NEG_SIZE  = 3'd2;
  localparam logic [2:0] ERR_MISMATCH  = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd4;
  localparam logic [2:0] ERR_TOO_MANY  = 3'd5;

  typedef enum logic [3:0] {
    PH_ARR_MARK  = 4'd0,
    PH_ARR_NUM   = 4'd1,
    PH_ARR_LF    = 4'd2,
    PH_BULK_MARK = 4'd3,
    PH_BULK_NUM  = 4'd4,
    PH_BULK_LF   = 4'd5,
    PH_DATA      = 4'd6,
    PH_DATA_CR   = 4'd7,
    PH_DATA_LF   = 4'd8,
    PH_DISCARD   = 4'd9
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [ACC_W-1:0] accum;
    logic             minus_seen;
    logic [CNT_W-1:0] elements_left;
    logic [CNT_W-1:0] cur_idx;
    logic [CNT_W-1:0] line_length;
    logic             prev_cr;
  } st_t;

  typedef struct packed {
    logic             valid;
    logic [2:0]       event_res;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] element_index;
    logic             last_of_request;
    logic [2:0]       error_code;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/rrp_step.sv
// Parser step: next state and optional result for one received byte.
// Depends on rrp_pkg.
`default_nettype none

module rrp_step #(
  parameter int LEN_BITS = rrp_pkg::LEN_BITS_DEF
) (
  input  rrp_pkg::st_t                 st_i,
  input  logic [LEN_BITS-1:0]          bytes_left_i,
  input  logic [7:0]                   byte_i,
  input  logic [rrp_pkg::CFG_W-1:0]    max_line_len_i,
  input  logic [rrp_pkg::CFG_W-1:0]    max_elements_i,
  output rrp_pkg::st_t                 st_o,
  output logic [LEN_BITS-1:0]          bytes_left_o,
  output rrp_pkg::res_t                res_o
);

  localparam int CMP_W = (LEN_BITS > rrp_pkg::ACC_W) ? LEN_BITS : rrp_pkg::ACC_W;
  localparam logic [LEN_BITS-1:0] LEN_ONES = {LEN_BITS{1'b1}};

  logic                       is_digit;
  logic                       crlf;
  logic [rrp_pkg::CNT_W-1:0]  ll_inc;
  logic [rrp_pkg::CNT_W-1:0]  bulk_min;
  logic [20:0]                acc_mul;
  logic [rrp_pkg::ACC_W-1:0]  acc_sat;
  logic [CMP_W-1:0]           acc_ext;
  logic [CMP_W-1:0]           len_max_ext;
  logic [LEN_BITS-1:0]        bl_dec;
  logic                       fail;
  logic [2:0]                 fail_code;
  logic                       fin;
  logic [2:0]                 fin_ev;
  logic                       fin_last;

  assign is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign crlf     = (byte_i == rrp_pkg::CH_LF) && st_i.prev_cr;
  assign ll_inc   = st_i.line_length + 16'd1;
  assign bulk_min = 16'd3 + {15'd0, st_i.minus_seen};

  // accum * 10 + digit, saturated
  assign acc_mul = ({4'd0, st_i.accum} << 3) + ({4'd0, st_i.accum} << 1)
                 + {17'd0, byte_i[3:0]};
  assign acc_sat = (acc_mul > {4'd0, rrp_pkg::ACC_MAX}) ? rrp_pkg::ACC_MAX
                                                         : acc_mul[rrp_pkg::ACC_W-1:0];

  assign acc_ext     = CMP_W'(st_i.accum);
  assign len_max_ext = CMP_W'(LEN_ONES);
  assign bl_dec      = bytes_left_i - LEN_BITS'(1);
  assign fin_last    = (st_i.elements_left <= 16'd1);

  always_comb begin
    st_o         = st_i;
    bytes_left_o = bytes_left_i;
    res_o        = '0;
    fail         = 1'b0;
    fail_code    = rrp_pkg::ERR_ARRAY_HDR;
    fin          = 1'b0;
    fin_ev       = rrp_pkg::EV_DONE;

    st_o.prev_cr = (byte_i == rrp_pkg::CH_CR);

    if (st_i.phase == rrp_pkg::PH_DISCARD) begin
      // drop bytes until CR LF closes the bad line
      if (crlf) begin
        st_o.phase         = rrp_pkg::PH_ARR_MARK;
        st_o.line_length   = '0;
        st_o.cur_idx       = '0;
        st_o.elements_left = '0;
      end
    end else if (st_i.line_length >= max_line_len_i) begin
      fail      = 1'b1;
      fail_code = rrp_pkg::ERR_TOO_LONG;
    end else begin
      st_o.line_length = ll_inc;
      unique case (st_i.phase)
        rrp_pkg::PH_ARR_MARK: begin
          if (byte_i != rrp_pkg::CH_STAR) begin
            fail = 1'b1;
          end else begin
            st_o.accum = '0;
            st_o.phase = rrp_pkg::PH_ARR_NUM;
          end
        end
        rrp_pkg::PH_ARR_NUM: begin
          if (is_digit) begin
            st_o.accum = acc_sat;
          end else if (byte_i == rrp_pkg::CH_CR && ll_inc >= 16'd3) begin
            st_o.phase = rrp_pkg::PH_ARR_LF;
          end else begin
            fail = 1'b1;
          end
        end
        rrp_pkg::PH_ARR_LF: begin
          if (byte_i != rrp_pkg::CH_LF) begin
            fail = 1'b1;
          end else if (st_i.accum > {1'b0, max_elements_i}) begin
            fail      = 1'b1;
            fail_code = rrp_pkg::ERR_TOO_MANY;
          end else if (st_i.accum == '0) begin
            st_o.phase               = rrp_pkg::PH_ARR_MARK;
            st_o.line_length         = '0;
            st_o.cur_idx             = '0;
            st_o.elements_left       = '0;
            res_o.valid              = 1'b1;
            res_o.event_res          = rrp_pkg::EV_EMPTY;
            res_o.last_of_request    = 1'b1;
          end else begin
            st_o.elements_left = st_i.accum[rrp_pkg::CNT_W-1:0];
            st_o.cur_idx       = '0;
            st_o.line_length   = '0;
            st_o.phase         = rrp_pkg::PH_BULK_MARK;
          end
        end
        rrp_pkg::PH_BULK_MARK: begin
          if (byte_i != rrp_pkg::CH_DOLLAR) begin
            fail      = 1'b1;
            fail_code = rrp_pkg::ERR_BULK_HDR;
          end else begin
            st_o.accum      = '0;
            st_o.minus_seen = 1'b0;
            st_o.phase      = rrp_pkg::PH_BULK_NUM;
          end
        end
        rrp_pkg::PH_BULK_NUM: begin
          if (byte_i == rrp_pkg::CH_MINUS && ll_inc == 16'd2) begin
            st_o.minus_seen = 1'b1;
          end else if (is_digit) begin
            st_o.accum = acc_sat;
          end else if (byte_i == rrp_pkg::CH_CR && ll_inc >= bulk_min) begin
            st_o.phase = rrp_pkg::PH_BULK_LF;
          end else begin
            fail      = 1'b1;
            fail_code = rrp_pkg::ERR_BULK_HDR;
          end
        end
        rrp_pkg::PH_BULK_LF: begin
          if (byte_i != rrp_pkg::CH_LF) begin
            fail      = 1'b1;
            fail_code = rrp_pkg::ERR_BULK_HDR;
          end else if (st_i.minus_seen && st_i.accum == 17'd1) begin
            fin    = 1'b1;
            fin_ev = rrp_pkg::EV_NULL;
          end else if (st_i.minus_seen && st_i.accum > 17'd1) begin
            fail      = 1'b1;
            fail_code = rrp_pkg::ERR_NEG_SIZE;
          end else if (acc_ext > len_max_ext) begin
            fail      = 1'b1;
            fail_code = rrp_pkg::ERR_TOO_LONG;
          end else begin
            bytes_left_o     = acc_ext[LEN_BITS-1:0];
            st_o.line_length = '0;
            st_o.phase       = (acc_ext == '0) ? rrp_pkg::PH_DATA_CR : rrp_pkg::PH_DATA;
          end
        end
        rrp_pkg::PH_DATA: begin
          if (crlf) begin
            fail      = 1'b1;
            fail_code = rrp_pkg::ERR_MISMATCH;
          end else begin
            bytes_left_o          = bl_dec;
            if (bl_dec == '0) begin
              st_o.phase = rrp_pkg::PH_DATA_CR;
            end
            res_o.valid           = 1'b1;
            res_o.event_res       = rrp_pkg::EV_DATA;
            res_o.data_byte       = byte_i;
            res_o.element_index   = st_i.cur_idx;
          end
        end
        rrp_pkg::PH_DATA_CR: begin
          if (byte_i != rrp_pkg::CH_CR) begin
            fail      = 1'b1;
            fail_code = rrp_pkg::ERR_MISMATCH;
          end else begin
            st_o.phase = rrp_pkg::PH_DATA_LF;
          end
        end
        rrp_pkg::PH_DATA_LF: begin
          if (byte_i != rrp_pkg::CH_LF) begin
            fail      = 1'b1;
            fail_code = rrp_pkg::ERR_MISMATCH;
          end else begin
            fin = 1'b1;
          end
        end
        default: begin
          st_o.phase = rrp_pkg::PH_DISCARD;
        end
      endcase
    end

    if (fail) begin
      res_o.valid         = 1'b1;
      res_o.event_res     = rrp_pkg::EV_ERROR;
      res_o.element_index = st_i.cur_idx;
      res_o.error_code    = fail_code;
      if (crlf) begin
        st_o.phase         = rrp_pkg::PH_ARR_MARK;
        st_o.line_length   = '0;
        st_o.cur_idx       = '0;
        st_o.elements_left = '0;
      end else begin
        st_o.phase = rrp_pkg::PH_DISCARD;
      end
    end

    if (fin) begin
      res_o.valid           = 1'b1;
      res_o.event_res       = fin_ev;
      res_o.element_index   = st_i.cur_idx;
      res_o.last_of_request = fin_last;
      if (fin_last) begin
        st_o.phase         = rrp_pkg::PH_ARR_MARK;
        st_o.line_length   = '0;
        st_o.cur_idx       = '0;
        st_o.elements_left = '0;
      end else begin
        st_o.elements_left = st_i.elements_left - 16'd1;
        st_o.cur_idx       = st_i.cur_idx + 16'd1;
        st_o.line_length   = '0;
        st_o.phase         = rrp_pkg::PH_BULK_MARK;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/resp_request_parser_top.sv
// Request stream parser, top level: input register, parser state, result register.
// Depends on rrp_pkg, rrp_step and resp_request_parser_top_defines.svh.
//
// Takes one byte per clock and sustains that rate indefinitely while the
// result side keeps up. A byte's result enters the result register when the
// parser step fires on the byte held in the input register; the parser step,
// whose whole per-byte update (header checks, decimal accumulate, counters)
// sits between the input register and the result register, is combinational.
// At most one result per byte; bytes that produce none never occupy the
// result register. A stalled result holds the parser; the input stalls
// once the input register is also full. No clearing pass after reset.
// Configuration writes are registered and must only be issued while the
// parser holds no bytes in flight.
`default_nettype none

`include "resp_request_parser_top_defines.svh"

module resp_request_parser_top #(
  parameter int LEN_BITS = rrp_pkg::LEN_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_event_res,
  output logic [7:0]                        out_data_byte,
  output logic [rrp_pkg::CNT_W-1:0]         out_element_index,
  output logic                              out_last_of_request,
  output logic [2:0]                        out_error_code,
  input  logic                              cfg_we,
  input  logic [rrp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrp_pkg::CFG_W-1:0]         cfg_wdata
);

  logic                       in_valid_r;
  logic [7:0]                 in_byte_r;
  logic [rrp_pkg::CFG_W-1:0]  max_line_len_r;
  logic [rrp_pkg::CFG_W-1:0]  max_elements_r;
  rrp_pkg::st_t               st_r;
  rrp_pkg::st_t               st_nxt;
  logic [LEN_BITS-1:0]        bytes_left_r;
  logic [LEN_BITS-1:0]        bytes_left_nxt;
  rrp_pkg::res_t              res;
  rrp_pkg::res_t              out_r;
  logic                       fire;
  logic                       in_xfer;

  // parser advances only when the result register can take a result
  assign fire     = in_valid_r && (!out_r.valid || !out_stall);
  assign in_stall = in_valid_r && !fire;
  assign in_xfer  = in_valid && !in_stall;

  rrp_step #(
    .LEN_BITS (LEN_BITS)
  ) u_step (
    .st_i           (st_r),
    .bytes_left_i   (bytes_left_r),
    .byte_i         (in_byte_r),
    .max_line_len_i (max_line_len_r),
    .max_elements_i (max_elements_r),
    .st_o           (st_nxt),
    .bytes_left_o   (bytes_left_nxt),
    .res_o          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_len_r <= rrp_pkg::CFG_RESET_VAL;
      max_elements_r <= rrp_pkg::CFG_RESET_VAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrp_pkg::CFG_MAX_LINE_LEN: max_line_len_r <= cfg_wdata;
        rrp_pkg::CFG_MAX_ELEMENTS: max_elements_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= rrp_pkg::PH_ARR_MARK;
      st_r.accum         <= '0;
      st_r.minus_seen    <= 1'b0;
      st_r.elements_left <= '0;
      st_r.cur_idx       <= '0;
      st_r.line_length   <= '0;
      st_r.prev_cr       <= 1'b0;
      bytes_left_r       <= '0;
    end else if (fire) begin
      st_r         <= st_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (fire && res.valid) begin
      out_r.valid <= 1'b1;
    end else if (!out_stall) begin
      out_r.valid <= 1'b0;
    end
    if (fire && res.valid) begin
      out_r.event_res       <= res.event_res;
      out_r.data_byte       <= res.data_byte;
      out_r.element_index   <= res.element_index;
      out_r.last_of_request <= res.last_of_request;
      out_r.error_code      <= res.error_code;
    end
  end

  assign out_valid           = out_r.valid;
  assign out_event_res       = out_r.event_res;
  assign out_data_byte       = out_r.data_byte;
  assign out_element_index   = out_r.element_index;
  assign out_last_of_request = out_r.last_of_request;
  assign out_error_code      = out_r.error_code;

  `RRP_ASSERT_NOW(a_no_result_overwrite, out_r.valid && out_stall, !fire)
  `RRP_ASSERT_NOW(a_discard_silent, fire && st_r.phase == rrp_pkg::PH_DISCARD, !res.valid)
  `RRP_ASSERT_NEXT(a_transfer_held, in_xfer, in_valid_r)
  `RRP_ASSERT_NOW(a_data_clean, out_r.valid && out_r.event_res == rrp_pkg::EV_DATA,
                  !out_r.last_of_request && out_r.error_code == rrp_pkg::ERR_ARRAY_HDR)

endmodule

`default_nettype wire

>>> bench/tb_resp_request_parser_top.sv
`timescale 1ns / 1ps
// Self-checking bench for resp_request_parser_top: directed request streams, then random ones.
// Uses rrp_pkg for codes and register indexes; predicts every event from its own parser copy.
module tb_resp_request_parser_top;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam int LEN_LIMIT = 65535;

  typedef struct packed {
    logic [2:0]                ev;
    logic [7:0]                data;
    logic [rrp_pkg::CNT_W-1:0] idx;
    logic                      last;
    logic [2:0]                err;
  } parse_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_event_res;
  logic [7:0] out_data_byte;
  logic [rrp_pkg::CNT_W-1:0] out_element_index;
  logic out_last_of_request;
  logic [2:0] out_error_code;
  logic cfg_we = 1'b0;
  logic [rrp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rrp_pkg::CFG_W-1:0] cfg_wdata = '0;

  resp_request_parser_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte             (in_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_res       (out_event_res),
    .out_data_byte       (out_data_byte),
    .out_element_index   (out_element_index),
    .out_last_of_request (out_last_of_request),
    .out_error_code      (out_error_code),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // Parser copy and its limits
  rrp_pkg::phase_t ph;
  int acc;
  bit neg;
  int elems_left;
  logic [rrp_pkg::CNT_W-1:0] cur_idx;
  int bytes_left;
  int line_len;
  bit prev_cr;
  int lim_line;
  int lim_elems;

  parse_event_t awaited_events[$];
  bit idle_on = 1'b1;
  int mismatches = 0;
  int bytes_parsed = 0;
  int out_hold = 0;
  int unsigned cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void restart();
    ph = rrp_pkg::PH_ARR_MARK;
    line_len = 0;
    cur_idx = '0;
    elems_left = 0;
  endfunction

  function automatic void reset_parser();
    lim_line = 1024;
    lim_elems = 1024;
    acc = 0;
    neg = 1'b0;
    bytes_left = 0;
    prev_cr = 1'b0;
    restart();
  endfunction

  function automatic bit fault(input logic [2:0] code, input bit lf_after_cr,
                               output parse_event_t r);
    r = '0;
    r.ev = rrp_pkg::EV_ERROR;
    r.idx = cur_idx;
    r.err = code;
    if (lf_after_cr) restart();
    else ph = rrp_pkg::PH_DISCARD;
    return 1'b1;
  endfunction

  function automatic bit finish_element(input logic [2:0] ev, output parse_event_t r);
    r = '0;
    r.ev = ev;
    r.idx = cur_idx;
    r.last = (elems_left <= 1);
    if (elems_left <= 1) begin
      restart();
    end else begin
      elems_left--;
      cur_idx++;
      line_len = 0;
      ph = rrp_pkg::PH_BULK_MARK;
    end
    return 1'b1;
  endfunction

  function automatic void accumulate(input logic [7:0] b);
    acc = acc * 10 + int'(b - CH_ZERO);
    if (acc > int'(rrp_pkg::ACC_MAX)) acc = int'(rrp_pkg::ACC_MAX);
  endfunction

  // Advance the parser copy by one byte; return 1 with the event it raises.
  function automatic bit parse_byte(input logic [7:0] b, output parse_event_t r);
    bit was_cr;
    bit digit;
    bit lf_cr;
    was_cr = prev_cr;
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    lf_cr = (b == rrp_pkg::CH_LF) && was_cr;
    prev_cr = (b == rrp_pkg::CH_CR);
    r = '0;
    if (ph == rrp_pkg::PH_DISCARD) begin
      if (lf_cr) restart();
      return 1'b0;
    end
    if (line_len >= lim_line) return fault(rrp_pkg::ERR_TOO_LONG, lf_cr, r);
    line_len++;
    case (ph)
      rrp_pkg::PH_ARR_MARK: begin
        if (b != rrp_pkg::CH_STAR) return fault(rrp_pkg::ERR_ARRAY_HDR, lf_cr, r);
        acc = 0;
        ph = rrp_pkg::PH_ARR_NUM;
        return 1'b0;
      end
      rrp_pkg::PH_ARR_NUM: begin
        if (digit) begin
          accumulate(b);
          return 1'b0;
        end
        if (b == rrp_pkg::CH_CR && line_len >= 3) begin
          ph = rrp_pkg::PH_ARR_LF;
          return 1'b0;
        end
        return fault(rrp_pkg::ERR_ARRAY_HDR, lf_cr, r);
      end
      rrp_pkg::PH_ARR_LF: begin
        if (b != rrp_pkg::CH_LF) return fault(rrp_pkg::ERR_ARRAY_HDR, lf_cr, r);
        if (acc > lim_elems) return fault(rrp_pkg::ERR_TOO_MANY, lf_cr, r);
        if (acc == 0) begin
          restart();
          r.ev = rrp_pkg::EV_EMPTY;
          r.last = 1'b1;
          return 1'b1;
        end
        elems_left = acc;
        cur_idx = '0;
        line_len = 0;
        ph = rrp_pkg::PH_BULK_MARK;
        return 1'b0;
      end
      rrp_pkg::PH_BULK_MARK: begin
        if (b != rrp_pkg::CH_DOLLAR) return fault(rrp_pkg::ERR_BULK_HDR, lf_cr, r);
        acc = 0;
        neg = 1'b0;
        ph = rrp_pkg::PH_BULK_NUM;
        return 1'b0;
      end
      rrp_pkg::PH_BULK_NUM: begin
        if (b == rrp_pkg::CH_MINUS && line_len == 2) begin
          neg = 1'b1;
          return 1'b0;
        end
        if (digit) begin
          accumulate(b);
          return 1'b0;
        end
        if (b == rrp_pkg::CH_CR && line_len >= 3 + int'(neg)) begin
          ph = rrp_pkg::PH_BULK_LF;
          return 1'b0;
        end
        return fault(rrp_pkg::ERR_BULK_HDR, lf_cr, r);
      end
      rrp_pkg::PH_BULK_LF: begin
        if (b != rrp_pkg::CH_LF) return fault(rrp_pkg::ERR_BULK_HDR, lf_cr, r);
        if (neg && acc == 1) return finish_element(rrp_pkg::EV_NULL, r);
        if (neg && acc > 1) return fault(rrp_pkg::ERR_NEG_SIZE, lf_cr, r);
        if (acc > LEN_LIMIT) return fault(rrp_pkg::ERR_TOO_LONG, lf_cr, r);
        bytes_left = acc;
        line_len = 0;
        ph = (bytes_left != 0) ? rrp_pkg::PH_DATA : rrp_pkg::PH_DATA_CR;
        return 1'b0;
      end
      rrp_pkg::PH_DATA: begin
        if (lf_cr) return fault(rrp_pkg::ERR_MISMATCH, lf_cr, r);
        bytes_left--;
        if (bytes_left == 0) ph = rrp_pkg::PH_DATA_CR;
        r.ev = rrp_pkg::EV_DATA;
        r.data = b;
        r.idx = cur_idx;
        return 1'b1;
      end
      rrp_pkg::PH_DATA_CR: begin
        if (b != rrp_pkg::CH_CR) return fault(rrp_pkg::ERR_MISMATCH, lf_cr, r);
        ph = rrp_pkg::PH_DATA_LF;
        return 1'b0;
      end
      default: begin
        if (b != rrp_pkg::CH_LF) return fault(rrp_pkg::ERR_MISMATCH, lf_cr, r);
        return finish_element(rrp_pkg::EV_DONE, r);
      end
    endcase
  endfunction

  task automatic report(input string what);
    if (mismatches < 40) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Check each result transfer and draw the hold for the next one.
  always @(posedge clk) begin
    parse_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_events.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = awaited_events.pop_front();
        if (out_event_res !== want.ev)
          report($sformatf("event %0d, expected %0d", out_event_res, want.ev));
        if (out_data_byte !== want.data)
          report($sformatf("data byte %h, expected %h", out_data_byte, want.data));
        if (out_element_index !== want.idx)
          report($sformatf("element index %0d, expected %0d", out_element_index, want.idx));
        if (out_last_of_request !== want.last)
          report($sformatf("last flag %b, expected %b", out_last_of_request, want.last));
        if (out_error_code !== want.err)
          report($sformatf("error code %0d, expected %0d", out_error_code, want.err));
      end
      out_hold = idle_on ? int'($urandom_range(0, 19)) : 0;
    end else if (out_valid && out_hold > 0) begin
      out_hold--;
    end
  end

  always @(negedge clk) out_stall <= (out_hold > 0);

  task automatic send_byte(input logic [7:0] b);
    int gap;
    parse_event_t r;
    gap = idle_on ? int'($urandom_range(0, 19)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    if (ph != rrp_pkg::PH_DISCARD) bytes_parsed++;
    if (parse_byte(b, r)) awaited_events.push_back(r);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_byte(rrp_pkg::CH_CR);
    send_byte(rrp_pkg::CH_LF);
  endtask

  // Drop valid and hold off until every awaited event has come out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rrp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rrp_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == rrp_pkg::CFG_MAX_LINE_LEN) lim_line = int'(val);
    else lim_elems = int'(val);
  endtask

  task automatic test_well_formed();
    send_line("*2");
    send_line("$3");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_line("a");
    send_line("$-1");
    send_line("*1");
    send_line("$4");
    send_line("wxyz");
  endtask

  task automatic test_empty_and_zero_length();
    send_line("*0");
    send_line("*1");
    send_line("$0");
    send_line("");
    send_line("*1");
    send_line("$-0");
    send_line("");
  endtask

  task automatic test_header_errors();
    send_line("x");
    send_line("*");
    send_text("*1");
    send_byte(rrp_pkg::CH_CR);
    send_line("x");
    send_text("*1");
    send_byte(rrp_pkg::CH_LF);
    send_line("");
    send_line("*1");
    send_line("#");
    send_line("*1");
    send_line("$-");
    send_line("*1");
    send_line("$1-");
    send_line("*1");
    send_text("$1");
    send_byte(rrp_pkg::CH_CR);
    send_line("y");
    send_line("*1");
    send_line("$");
  endtask

  task automatic test_negative_sizes();
    send_line("*3");
    send_line("$-1");
    send_line("$-0");
    send_line("");
    send_line("$-2");
  endtask

  task automatic test_data_mismatch();
    // CR LF inside the data
    send_line("*1");
    send_line("$3");
    send_line("a");
    send_line("*2");
    send_line("$1");
    send_line("ab");
    send_line("*1");
    send_line("$1");
    send_text("a");
    send_byte(rrp_pkg::CH_CR);
    send_line("x");
  endtask

  task automatic test_oversized_numbers();
    send_line("*1");
    send_line("$65536");
    send_line("*1");
    send_line("$999999999");
    send_line("*9999999");
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(rrp_pkg::CFG_MAX_LINE_LEN, 16'd4);
    write_reg(rrp_pkg::CFG_MAX_ELEMENTS, 16'd0);
    send_line("*0");
    send_line("*1");
    send_line("*12");
    settle();
    write_reg(rrp_pkg::CFG_MAX_ELEMENTS, 16'hFFFF);
    send_line("*1");
    send_line("$2");
    send_line("ab");
    // data line one byte past the limit
    send_line("*1");
    send_line("$3");
    send_line("abc");
    settle();
    write_reg(rrp_pkg::CFG_MAX_LINE_LEN, 16'hFFFF);
    send_line("*65536");
    send_line("*65535");
    send_line("$0");
    send_line("");
    send_line("$-1");
    send_line("*1");
    settle();
    write_reg(rrp_pkg::CFG_MAX_LINE_LEN, 16'd1024);
    write_reg(rrp_pkg::CFG_MAX_ELEMENTS, 16'd1024);
  endtask

  task automatic push_line(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    q.push_back(rrp_pkg::CH_CR);
    q.push_back(rrp_pkg::CH_LF);
  endtask

  task automatic build_request(ref logic [7:0] q[$]);
    int count;
    int len;
    count = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 4));
    push_line(q, $sformatf("*%0d", count));
    for (int e = 0; e < count; e++) begin
      case ($urandom_range(0, 9))
        0: push_line(q, "$-1");
        1: begin
          push_line(q, "$-0");
          push_line(q, "");
        end
        default: begin
          len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(9, 30))
                                            : int'($urandom_range(0, 8));
          push_line(q, $sformatf("$%0d", len));
          repeat (len) q.push_back(8'($urandom_range(0, 255)));
          push_line(q, "");
        end
      endcase
    end
  endtask

  task automatic test_random_traffic();
    logic [7:0] q[$];
    int start;
    int cut;
    logic [rrp_pkg::CFG_W-1:0] line_sel;
    logic [rrp_pkg::CFG_W-1:0] elem_sel;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin line_sel = 16'd1024; elem_sel = 16'd1024; end
        1: begin line_sel = 16'd4; elem_sel = 16'hFFFF; end
        2: begin line_sel = 16'hFFFF; elem_sel = 16'd0; end
        3: begin
          line_sel = 16'($urandom_range(5, 16));
          elem_sel = 16'($urandom_range(1, 4));
        end
        4: begin
          line_sel = 16'($urandom_range(17, 64));
          elem_sel = 16'($urandom_range(0, 3));
        end
        5: begin line_sel = 16'hFFFF; elem_sel = 16'hFFFF; end
        6: begin line_sel = 16'd4; elem_sel = 16'd2; end
        default: begin
          line_sel = 16'($urandom_range(4, 65535));
          elem_sel = 16'($urandom_range(2, 8));
        end
      endcase
      settle();
      write_reg(rrp_pkg::CFG_MAX_LINE_LEN, line_sel);
      write_reg(rrp_pkg::CFG_MAX_ELEMENTS, elem_sel);
      start = bytes_parsed;
      while (bytes_parsed - start < 90) begin
        idle_on = (p % 3 != 1) && ($urandom_range(0, 4) != 0);
        q = {};
        if ($urandom_range(0, 14) == 0) begin
          repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1) == 1) push_line(q, "");
        end
        build_request(q);
        case ($urandom_range(0, 11))
          0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
          1: begin
            cut = int'($urandom_range(1, q.size()));
            while (q.size() > cut) void'(q.pop_back());
          end
          default: ;
        endcase
        foreach (q[i]) send_byte(q[i]);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    reset_parser();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_well_formed();
    test_empty_and_zero_length();
    test_header_errors();
    test_negative_sizes();
    test_data_mismatch();
    test_oversized_numbers();
    test_register_extremes();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
